// ===== rtl/mrc_pkg.sv =====
// Shared types for the mixed-radix index converter.
// No dependencies; imported by mrc_entry and mixed_radix_index_converter.
package mrc_pkg;

   typedef enum logic [1:0] {
      MODE_FLATTEN = 2'd0,
      MODE_UNRAVEL = 2'd1,
      MODE_STEP    = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   // Status worked out on entry to the pipeline
   typedef struct packed {
      logic range_err;  // some digit 1..last at or above its radix
      logic wrap;       // odometer carried out of digit 0
   } check_type;

endpackage

// ===== rtl/mrc_entry.sv =====
// Entry checks: odometer carry chain and digit range test.
// Depends on mrc_pkg.
module mrc_entry #(
   parameter int DIGITS      = 6,
   parameter int DIGIT_WIDTH = 8
) (
   input  logic [DIGITS-1:0][DIGIT_WIDTH-1:0] digit,
   input  logic [DIGITS-1:0][DIGIT_WIDTH:0]   radix,
   output logic [DIGITS-1:0]                  carry,
   output mrc_pkg::check_type                 chk
);
   import mrc_pkg::*;

   logic [DIGITS-1:0] over;
   logic [DIGITS-1:0] bad;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         over[i] = ({1'b0, digit[i]} + 1'b1) >= radix[i];
         bad[i]  = (i != 0) && ({1'b0, digit[i]} >= radix[i]);
      end
      // carry into digit i: every less significant digit turned over
      carry[DIGITS-1] = 1'b1;
      for (int i = DIGITS - 2; i >= 0; i--) begin
         carry[i] = carry[i+1] & over[i+1];
      end
      chk.wrap      = carry[0] & over[0];
      chk.range_err = |bad;
   end

endmodule

// ===== rtl/mixed_radix_index_converter.sv =====
// Mixed-radix index converter: flatten, unravel and odometer step over DIGITS digits.
// Throughput: one request per cycle; a shared restoring divider pipeline retires
// up to eight quotient bits per stage per digit. The whole pipeline holds while rsp stalls.
// Reset (synchronous): valid bits cleared, every radix register set to 1.
// Depends on mrc_pkg and mrc_entry.
module mixed_radix_index_converter #(
   parameter int DIGITS      = 6,
   parameter int DIGIT_WIDTH = 8,
   parameter int INDEX_WIDTH = 48,
   localparam int REQ_BITS   = DIGITS * DIGIT_WIDTH + INDEX_WIDTH,
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = DIGITS * DIGIT_WIDTH + INDEX_WIDTH + 1,
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8,
   localparam int ADDR_W     = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // in_digit_0 .. in_digit_last, in_linear, zero fill
   input  logic [REQ_W-1:0]       req_tdata,
   // mode
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_digit_0 .. out_digit_last, out_linear, flag, zero fill
   output logic [RSP_W-1:0]       rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [ADDR_W-1:0]      csr_addr,
   input  logic [DIGIT_WIDTH:0]   csr_wdata
);
   import mrc_pkg::*;

   localparam int DW    = DIGIT_WIDTH;
   localparam int IW    = INDEX_WIDTH;
   localparam int QW    = (IW > DW) ? IW : DW + 1;
   localparam int STEP  = 8;
   localparam int NSUB  = (QW + STEP - 1) / STEP;
   localparam int NST   = DIGITS * NSUB;
   localparam logic [DW:0] RADIX_MAX = {1'b1, {DW{1'b0}}};
   localparam logic [DW:0] RADIX_ONE = {{DW{1'b0}}, 1'b1};

   typedef logic [DIGITS-1:0][DW-1:0] digits_type;

   // configuration
   logic [DW:0]            radix_ff [DIGITS];
   logic [DIGITS-1:0][DW:0] eff_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGITS; i++) radix_ff[i] <= RADIX_ONE;
      end else if (csr_wr_en && (int'(csr_addr) < DIGITS)) begin
         radix_ff[csr_addr] <= csr_wdata;
      end
   end

   for (genvar i = 0; i < DIGITS; i++) begin : g_radix
      always_comb begin
         if (radix_ff[i] == '0) eff_r[i] = RADIX_ONE;
         else if (radix_ff[i] > RADIX_MAX) eff_r[i] = RADIX_MAX;
         else eff_r[i] = radix_ff[i];
      end
   end

   // pipeline stage registers, stage 0 is the entry register
   logic                   vld_ff   [NST+1];
   mode_type               mode_ff  [NST+1];
   digits_type             dig_ff   [NST+1];
   digits_type             res_ff   [NST+1];
   logic [DIGITS-1:0]      carry_ff [NST+1];
   logic [QW-1:0]          q_ff     [NST+1];
   logic [DW-1:0]          rem_ff   [NST+1];
   logic [IW-1:0]          acc_ff   [NST+1];
   logic                   flag_ff  [NST+1];

   logic       adv;
   digits_type req_dig;
   mode_type   req_mode;
   logic [DIGITS-1:0] req_carry;
   check_type  req_chk;

   assign adv        = !vld_ff[NST] || rsp_tready;
   assign req_tready = adv;
   assign req_dig    = req_tdata[DIGITS*DW-1:0];
   assign req_mode   = mode_type'(req_tuser);

   mrc_entry #(
      .DIGITS      (DIGITS),
      .DIGIT_WIDTH (DW)
   ) u_entry (
      .digit (req_dig),
      .radix (eff_r),
      .carry (req_carry),
      .chk   (req_chk)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mode_ff[0]  <= req_mode;
         dig_ff[0]   <= req_dig;
         res_ff[0]   <= '0;
         carry_ff[0] <= req_carry;
         q_ff[0]     <= QW'(req_tdata[DIGITS*DW +: IW]);
         rem_ff[0]   <= '0;
         acc_ff[0]   <= IW'(req_dig[0]);
         flag_ff[0]  <= (req_mode == MODE_FLATTEN) ? req_chk.range_err :
                        (req_mode == MODE_STEP)    ? req_chk.wrap : 1'b0;
      end
   end

   // Phase p divides by the radix of digit DIGITS-1-p; for p above 0 its first
   // stage also takes one Horner step with the radix of digit p.
   for (genvar t = 1; t <= NST; t++) begin : g_stage
      localparam int P  = (t - 1) / NSUB;
      localparam int K  = (t - 1) % NSUB;
      localparam int D  = DIGITS - 1 - P;
      localparam int NB = ((QW - K * STEP) < STEP) ? (QW - K * STEP) : STEP;

      logic [QW-1:0]  q_v;
      logic [DW-1:0]  rem_v;
      logic [IW-1:0]  acc_v;
      logic [IW+DW:0] prod_v;
      logic [DW:0]    r2_v;
      digits_type     res_v;

      always_comb begin
         q_v    = q_ff[t-1];
         rem_v  = rem_ff[t-1];
         acc_v  = acc_ff[t-1];
         res_v  = res_ff[t-1];
         prod_v = '0;
         r2_v   = '0;
         if (K == 0) begin
            rem_v = '0;
            if (mode_ff[t-1] == MODE_STEP) begin
               q_v = QW'(dig_ff[t-1][D]) + QW'(1);
            end
            if (P > 0) begin
               prod_v = acc_v * eff_r[P];
               acc_v  = prod_v[IW-1:0] + IW'(dig_ff[t-1][P]);
            end
         end
         for (int j = 0; j < STEP; j++) begin
            if (j < NB) begin
               r2_v = {rem_v, q_v[QW-1]};
               q_v  = {q_v[QW-2:0], 1'b0};
               if (r2_v >= eff_r[D]) begin
                  r2_v   = r2_v - eff_r[D];
                  q_v[0] = 1'b1;
               end
               rem_v = r2_v[DW-1:0];
            end
         end
         if (K == NSUB - 1) begin
            unique case (mode_ff[t-1])
               MODE_UNRAVEL: res_v[D] = rem_v;
               MODE_STEP:    res_v[D] = carry_ff[t-1][D] ? rem_v : dig_ff[t-1][D];
               default:      res_v[D] = '0;
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[t] <= 1'b0;
         end else if (adv) begin
            vld_ff[t] <= vld_ff[t-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            mode_ff[t]  <= mode_ff[t-1];
            dig_ff[t]   <= dig_ff[t-1];
            res_ff[t]   <= res_v;
            carry_ff[t] <= carry_ff[t-1];
            q_ff[t]     <= q_v;
            rem_ff[t]   <= rem_v;
            acc_ff[t]   <= acc_v;
            flag_ff[t]  <= flag_ff[t-1];
         end
      end
   end

   // result
   logic [IW-1:0] out_linear;
   logic          out_flag;

   assign out_linear = (mode_ff[NST] == MODE_FLATTEN) ? acc_ff[NST] : '0;
   assign out_flag   = (mode_ff[NST] == MODE_UNRAVEL) ? (|q_ff[NST]) : flag_ff[NST];
   assign rsp_tvalid = vld_ff[NST];
   assign rsp_tdata  = RSP_W'({out_flag, out_linear, res_ff[NST]});

`ifndef SYNTHESIS
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_entry_moves: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && adv |=> vld_ff[1])
      else $error("entry request lost on its way into the divider");

   a_flatten_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (mode_ff[NST] == MODE_FLATTEN) |-> (res_ff[NST] == '0))
      else $error("flatten result carries digits");

   a_unravel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (mode_ff[NST] == MODE_UNRAVEL)
      |-> ({1'b0, res_ff[NST][DIGITS-1]} < eff_r[DIGITS-1]))
      else $error("unravelled digit not below its radix");
`endif

endmodule

// ===== tb/tb_mixed_radix_index_converter.sv =====
// Self-checking testbench for mixed_radix_index_converter: flatten, unravel and odometer step.
// Drives requests from a queue, predicts each response in-line and compares it field by field.
// Depends on mrc_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_mixed_radix_index_converter;
   import mrc_pkg::*;

   localparam int NDIG      = 6;
   localparam int LATENCY   = 37;
   localparam int LIMIT     = 2000000;
   localparam logic [63:0] IDX_MASK = 64'hFFFF_FFFF_FFFF;

   typedef struct packed {
      mode_type            mode;
      logic [47:0]         linear;
      logic [NDIG-1:0][7:0] digits;   // digit 0 in the low byte
   } conv_req_t;

   typedef struct packed {
      logic                flag;
      logic [47:0]         linear;
      logic [NDIG-1:0][7:0] digits;
   } conv_rsp_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [95:0]  req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic         csr_wr_en;
   logic [2:0]   csr_addr;
   logic [8:0]   csr_wdata;

   mixed_radix_index_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   conv_req_t   pending_reqs[$];
   conv_rsp_t   expected_rsps[$];
   logic [8:0]  radix_cfg[NDIG];
   int          errors;
   int          cycles;
   int          mode_count[4];
   int          flag_count;
   int          rsp_count;
   logic        req_taken;
   logic        no_idle;
   logic        hold_req;
   logic        hold_done;
   int          hold_left;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [63:0] eff_radix(int pos);
      if (radix_cfg[pos] == 9'd0) return 64'd1;
      if (radix_cfg[pos] > 9'd256) return 64'd256;
      return {55'd0, radix_cfg[pos]};
   endfunction

   function automatic conv_rsp_t convert(conv_req_t rq);
      conv_rsp_t   rs;
      logic [63:0] acc;
      logic [63:0] r;
      logic [63:0] s;
      logic        carry;
      rs = '0;
      case (rq.mode)
         MODE_FLATTEN: begin
            acc = {56'd0, rq.digits[0]};
            for (int i = 1; i < NDIG; i++) begin
               r = eff_radix(i);
               if (rq.digits[i] >= r) rs.flag = 1'b1;
               acc = (acc * r + rq.digits[i]) & IDX_MASK;
            end
            rs.linear = acc[47:0];
         end
         MODE_UNRAVEL: begin
            acc = {16'd0, rq.linear};
            for (int i = NDIG - 1; i >= 0; i--) begin
               r = eff_radix(i);
               rs.digits[i] = 8'(acc % r);
               acc = acc / r;
            end
            rs.flag = (acc != 0);
         end
         MODE_STEP: begin
            carry = 1'b1;
            rs.digits = rq.digits;
            for (int i = NDIG - 1; i >= 0; i--) begin
               if (carry) begin
                  r = eff_radix(i);
                  s = rq.digits[i] + 64'd1;
                  rs.digits[i] = 8'(s % r);
                  carry = (s / r) >= 1;
               end
            end
            rs.flag = carry;
         end
         default: rs = '0;
      endcase
      return rs;
   endfunction

   task automatic report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
   endtask

   // request side: new request offered at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_reqs.size() == 0 || (!no_idle && $urandom_range(0, 99) < 14)) begin
            req_tvalid <= 1'b0;
         end else begin
            conv_req_t rq;
            rq = pending_reqs.pop_front();
            req_tdata  <= {rq.linear, rq.digits};
            req_tuser  <= rq.mode;
            req_tvalid <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      conv_req_t rq;
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready) begin
         rq.mode   = mode_type'(req_tuser);
         rq.digits = req_tdata[47:0];
         rq.linear = req_tdata[95:48];
         expected_rsps.push_back(convert(rq));
         mode_count[req_tuser]++;
      end
   end

   // response side, including one long hold-off to back the pipeline up
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_done  <= 1'b1;
         hold_left  <= 300;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(0, 99) >= 14);
      end
   end

   always @(posedge clock) begin
      conv_rsp_t got;
      conv_rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[96:0];
         rsp_count++;
         if (rsp_tdata[103:97] != 0) report("fill bits above flag not zero");
         if (expected_rsps.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            want = expected_rsps.pop_front();
            if (want.flag) flag_count++;
            for (int i = 0; i < NDIG; i++)
               if (got.digits[i] != want.digits[i])
                  report($sformatf("out_digit_%0d got %0d want %0d", i,
                                   got.digits[i], want.digits[i]));
            if (got.linear != want.linear)
               report($sformatf("out_linear got %0h want %0h", got.linear, want.linear));
            if (got.flag != want.flag)
               report($sformatf("flag got %0b want %0b", got.flag, want.flag));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_radix(int idx, logic [8:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= 3'(idx);
      csr_wdata <= val;
      radix_cfg[idx] = val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_radices(logic [8:0] r0, logic [8:0] r1, logic [8:0] r2,
                              logic [8:0] r3, logic [8:0] r4, logic [8:0] r5);
      write_radix(0, r0);
      write_radix(1, r1);
      write_radix(2, r2);
      write_radix(3, r3);
      write_radix(4, r4);
      write_radix(5, r5);
   endtask

   // checked at the rising edge, where the request valid has settled
   task automatic drain();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0);
      repeat (LATENCY + 3) @(negedge clock);
   endtask

   function automatic conv_req_t mk(mode_type m, logic [47:0] dg, logic [47:0] lin);
      conv_req_t rq;
      rq.mode = m;
      rq.digits = dg;
      rq.linear = lin;
      return rq;
   endfunction

   // mostly in-range digits and indexes below the radix product, some raw noise
   function automatic conv_req_t random_req();
      conv_req_t   rq;
      logic [63:0] span;
      logic [63:0] r;
      int          sel;
      sel = $urandom_range(0, 99);
      rq.mode   = mode_type'($urandom_range(0, 2));
      if (sel < 4) rq.mode = MODE_NONE;
      rq.linear = {$urandom(), $urandom()} & IDX_MASK;
      for (int i = 0; i < NDIG; i++) rq.digits[i] = 8'($urandom());
      if (sel >= 25) begin
         span = 1;
         for (int i = 0; i < NDIG; i++) begin
            r = eff_radix(i);
            // odometer runs near the top digit value to provoke carries
            if (sel < 45) rq.digits[i] = 8'(r - 1 - $urandom_range(0, r > 1 ? 1 : 0));
            else rq.digits[i] = 8'($urandom_range(0, int'(r) - 1));
            if (span <= IDX_MASK) span = span * r;
         end
         if (span > IDX_MASK) span = IDX_MASK + 1;
         rq.linear = 48'(({$urandom(), $urandom()}) % (span + (sel < 35 ? span : 0)));
      end
      return rq;
   endfunction

   task automatic random_phase(int n);
      for (int k = 0; k < n; k++) pending_reqs.push_back(random_req());
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_FLATTEN;
      rsp_tready = 1'b0;
      csr_wr_en  = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      errors     = 0;
      cycles     = 0;
      flag_count = 0;
      rsp_count  = 0;
      req_taken  = 1'b0;
      no_idle    = 1'b0;
      hold_req   = 1'b0;
      for (int i = 0; i < 4; i++) mode_count[i] = 0;
      for (int i = 0; i < NDIG; i++) radix_cfg[i] = 9'd1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset radices, all ones
      pending_reqs.push_back(mk(MODE_FLATTEN, {6{8'hFF}}, 48'd0));
      pending_reqs.push_back(mk(MODE_UNRAVEL, '0, 48'hFFFF_FFFF_FFFF));
      pending_reqs.push_back(mk(MODE_STEP, '0, 48'd0));
      random_phase(60);
      drain();

      set_radices(9'd3, 9'd5, 9'd7, 9'd256, 9'd1, 9'd2);
      pending_reqs.push_back(mk(MODE_FLATTEN, '0, 48'd0));
      pending_reqs.push_back(mk(MODE_FLATTEN, {6{8'hFF}}, 48'hFFFF_FFFF_FFFF));
      pending_reqs.push_back(mk(MODE_FLATTEN, {8'd1, 8'd0, 8'd255, 8'd6, 8'd4, 8'd200}, 48'd0));
      pending_reqs.push_back(mk(MODE_UNRAVEL, {6{8'hFF}}, 48'd0));
      pending_reqs.push_back(mk(MODE_UNRAVEL, '0, 48'hFFFF_FFFF_FFFF));
      pending_reqs.push_back(mk(MODE_UNRAVEL, '0, 48'd53759));
      pending_reqs.push_back(mk(MODE_UNRAVEL, '0, 48'd53760));
      pending_reqs.push_back(mk(MODE_STEP, {8'd1, 8'd0, 8'd255, 8'd6, 8'd4, 8'd2}, 48'd0));
      pending_reqs.push_back(mk(MODE_STEP, {8'd0, 8'd0, 8'd255, 8'd6, 8'd4, 8'd1}, 48'd0));
      pending_reqs.push_back(mk(MODE_STEP, {8'd9, 8'd0, 8'd255, 8'd6, 8'd4, 8'd0}, 48'd0));
      pending_reqs.push_back(mk(MODE_STEP, {6{8'hFF}}, 48'd0));
      pending_reqs.push_back(mk(MODE_STEP, '0, 48'hFFFF_FFFF_FFFF));
      pending_reqs.push_back(mk(MODE_NONE, {6{8'hFF}}, 48'hFFFF_FFFF_FFFF));
      pending_reqs.push_back(mk(MODE_NONE, '0, 48'd0));
      random_phase(150);
      drain();

      // largest radices; their product spans the whole 48-bit linear range
      set_radices(9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256);
      no_idle = 1'b1;
      random_phase(150);
      drain();
      no_idle = 1'b0;

      // zero and oversized registers
      set_radices(9'd0, 9'd511, 9'd0, 9'd257, 9'd300, 9'd0);
      random_phase(150);
      drain();

      // small radices so the odometer wraps often; receiver holds off meanwhile
      set_radices(9'd2, 9'd1, 9'd3, 9'd2, 9'd1, 9'd2);
      hold_req = 1'b1;
      random_phase(200);
      drain();

      for (int p = 0; p < 4; p++) begin
         set_radices(9'($urandom()), 9'($urandom_range(1, 256)), 9'($urandom_range(1, 16)),
                     9'($urandom_range(1, 256)), 9'($urandom()), 9'($urandom_range(1, 8)));
         random_phase(130);
         drain();
      end

      wait (expected_rsps.size() == 0);
      repeat (LATENCY + 3) @(posedge clock);
      $display("covered %0d responses: flatten %0d, unravel %0d, step %0d, unused mode %0d",
               rsp_count, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
      $display("radix settings from 0 to 511 incl. reset values; %0d flagged responses",
               flag_count);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mrc_pkg.sv
rtl/mrc_entry.sv
rtl/mixed_radix_index_converter.sv
tb/tb_mixed_radix_index_converter.sv
